/* rtl/mdcs_pkg.sv */
// Types and constants shared by the motion and dispense command sequencer.
package mdcs_pkg;

   // Item kinds carried on the request channel's tuser.
   typedef enum logic [1:0] {
      ACT_ADD   = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_START = 2'd2,
      ACT_TICK  = 2'd3
   } action_type;

   // Command codes held in the program store.
   localparam logic [2:0] OP_NOP      = 3'd0;
   localparam logic [2:0] OP_MOVE     = 3'd1;
   localparam logic [2:0] OP_DISPENSE = 3'd2;
   localparam logic [2:0] OP_WAIT     = 3'd3;
   localparam logic [2:0] OP_HOME     = 3'd4;

   // Run state codes as reported on the result channel.
   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_RUN   = 2'd1;
   localparam logic [1:0] MODE_FAULT = 2'd2;

   // Configuration register indexes (byte address is four times the index).
   localparam logic [1:0] REG_STEPS_PER_CM      = 2'd0;
   localparam logic [1:0] REG_MAX_RAIL_POSITION = 2'd1;
   localparam logic [1:0] REG_MAX_MOVE_TICKS    = 2'd2;
   localparam logic [1:0] REG_SETTLE_TICKS      = 2'd3;

   localparam logic [15:0] STEPS_PER_CM_RESET      = 16'd100;
   localparam logic [18:0] MAX_RAIL_POSITION_RESET = 19'd20000;
   localparam logic [31:0] MAX_MOVE_TICKS_RESET    = 32'd20000;
   localparam logic [15:0] SETTLE_TICKS_RESET      = 16'd250;

   // Target of a home run, below the switch so the switch is always reached.
   localparam logic signed [19:0] HOME_TARGET = -20'sd500;

   // One command of the program list.
   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] param_a;
      logic [15:0] param_b;
   } entry_type;

   // Result item, last field in the lowest bits.
   typedef struct packed {
      logic               drive_off;
      logic               home_found;
      logic               stop_all;
      logic [15:0]        dispense_amount;
      logic [4:0]         dispense_unit;
      logic               dispense_cmd;
      logic               homing_speed;
      logic signed [19:0] move_target;
      logic               move_cmd;
      logic [1:0]         run_state;
      logic               accepted;
   } result_type;

endpackage

/* rtl/mdcs_ram.sv */
// Generic RAM with one write port and two registered, write-first read ports.
module mdcs_ram #(
   parameter int WIDTH      = 35,
   parameter int DEPTH      = 32,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr_a,
   output logic [WIDTH-1:0]      rd_data_a,
   input  logic [ADDR_WIDTH-1:0] rd_addr_b,
   output logic [WIDTH-1:0]      rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // A read of the address being written returns the new data.
      if (wr_en && (wr_addr == rd_addr_a)) begin
         rd_data_a_ff <= wr_data;
      end else begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
      end
      if (wr_en && (wr_addr == rd_addr_b)) begin
         rd_data_b_ff <= wr_data;
      end else begin
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

/* rtl/motion_dispense_command_sequencer.sv */
// Command-list sequencer for a rail platform and dispensers.
//
//   channel  direction  handshake                 payload
//   req      in         req_tvalid / req_tready   req_tdata, req_tuser (kind of item)
//   rsp      out        rsp_tvalid / rsp_tready   rsp_tdata, one result per request
//   csr      in         csr_psel / csr_penable    32-bit registers at 0x0, 0x4, 0x8, 0xC
//
// One request is taken per cycle while req_tready is high; its result is registered.
// All state of the sequencer updates in the cycle of the transfer; the program store has
// two registered read ports addressed from the next step, so the current and the following
// command are ready when the next tick arrives.
// Reset clears the list length, step, run state and counters; there is no clearing pass.
// A two-entry output buffer absorbs one stalled result; req_tready drops only when both
// entries are full.
module motion_dispense_command_sequencer #(
   parameter int PROGRAM_DEPTH = 32,
   parameter int UNIT_COUNT    = 21
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] op, [18:3] param_a, [34:19] param_b, [35] limit_hit, [36] at_target,
   // [37] dispenser_idle, [39:38] zero
   input  logic [39:0] req_tdata,
   // [1:0] action
   input  logic [1:0]  req_tuser,
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] accepted, [2:1] run_state, [3] move_cmd, [23:4] move_target, [24] homing_speed,
   // [25] dispense_cmd, [30:26] dispense_unit, [46:31] dispense_amount, [47] stop_all,
   // [48] home_found, [49] drive_off, [55:50] zero
   output logic [55:0] rsp_tdata,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int LEN_WIDTH = $clog2(PROGRAM_DEPTH + 1);
   localparam int IDX_WIDTH = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
   localparam int PAD_WIDTH = 56 - $bits(mdcs_pkg::result_type);

   // Configuration registers.
   logic [15:0] steps_per_cm_ff;
   logic [18:0] max_rail_position_ff;
   logic [31:0] max_move_ticks_ff;
   logic [15:0] settle_ticks_ff;
   logic        csr_write;

   // Sequencer state.
   logic [LEN_WIDTH-1:0] length_ff, length_in;
   logic [LEN_WIDTH-1:0] step_ff, step_in, step_next_in;
   logic [1:0]           mode_ff, mode_in;
   logic signed [19:0]   last_target_ff, last_target_in;
   logic [31:0]          move_elapsed_ff, move_elapsed_in;
   logic [31:0]          wait_elapsed_ff, wait_elapsed_in;
   mdcs_pkg::entry_type  entry0_ff;

   // Output buffer.
   mdcs_pkg::result_type out_ff, skid_ff;
   logic                 out_valid_ff, skid_valid_ff;
   logic                 rsp_pop;

   // Request decode.
   mdcs_pkg::action_type action;
   logic [2:0]           op;
   logic [15:0]          param_a;
   logic [15:0]          param_b;
   logic                 limit_hit;
   logic                 at_target;
   logic                 dispenser_idle;
   logic                 accept;

   // Program store access.
   mdcs_pkg::entry_type  new_entry;
   mdcs_pkg::entry_type  cur_entry;
   mdcs_pkg::entry_type  nxt_entry;
   mdcs_pkg::entry_type  issue_entry;
   logic                 wr_en;

   // Datapath.
   mdcs_pkg::result_type res;
   logic                 add_ok;
   logic                 do_issue;
   logic                 issue_valid;
   logic [31:0]          move_prod;
   logic [18:0]          move_pos;
   logic [31:0]          move_sat;
   logic [31:0]          wait_sat;
   logic                 limit_fault;
   logic [2:0]           cur_op;
   logic [15:0]          cur_a;
   logic                 done;
   logic                 fault;

   assign action         = mdcs_pkg::action_type'(req_tuser);
   assign op             = req_tdata[2:0];
   assign param_a        = req_tdata[18:3];
   assign param_b        = req_tdata[34:19];
   assign limit_hit      = req_tdata[35];
   assign at_target      = req_tdata[36];
   assign dispenser_idle = req_tdata[37];

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign rsp_pop    = out_valid_ff && rsp_tready;

   // ---------------------------------------------------------------- configuration port

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[3:2])
         mdcs_pkg::REG_STEPS_PER_CM:      csr_prdata = {16'b0, steps_per_cm_ff};
         mdcs_pkg::REG_MAX_RAIL_POSITION: csr_prdata = {13'b0, max_rail_position_ff};
         mdcs_pkg::REG_MAX_MOVE_TICKS:    csr_prdata = max_move_ticks_ff;
         mdcs_pkg::REG_SETTLE_TICKS:      csr_prdata = {16'b0, settle_ticks_ff};
         default:                         csr_prdata = 32'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_per_cm_ff      <= mdcs_pkg::STEPS_PER_CM_RESET;
         max_rail_position_ff <= mdcs_pkg::MAX_RAIL_POSITION_RESET;
         max_move_ticks_ff    <= mdcs_pkg::MAX_MOVE_TICKS_RESET;
         settle_ticks_ff      <= mdcs_pkg::SETTLE_TICKS_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            mdcs_pkg::REG_STEPS_PER_CM:      steps_per_cm_ff      <= csr_pwdata[15:0];
            mdcs_pkg::REG_MAX_RAIL_POSITION: max_rail_position_ff <= csr_pwdata[18:0];
            mdcs_pkg::REG_MAX_MOVE_TICKS:    max_move_ticks_ff    <= csr_pwdata;
            mdcs_pkg::REG_SETTLE_TICKS:      settle_ticks_ff      <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- program store

   assign new_entry.op      = op;
   assign new_entry.param_a = param_a;
   assign new_entry.param_b = param_b;

   assign step_next_in = step_in + LEN_WIDTH'(1);

   // Port a holds the command at the step, port b the one after it, both for the next item.
   mdcs_ram #(
      .WIDTH      ($bits(mdcs_pkg::entry_type)),
      .DEPTH      (PROGRAM_DEPTH),
      .ADDR_WIDTH (IDX_WIDTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (length_ff[IDX_WIDTH-1:0]),
      .wr_data   (new_entry),
      .rd_addr_a (step_in[IDX_WIDTH-1:0]),
      .rd_data_a (cur_entry),
      .rd_addr_b (step_next_in[IDX_WIDTH-1:0]),
      .rd_data_b (nxt_entry)
   );

   // ---------------------------------------------------------------- sequencer

   // A start issues the first command, which is kept in its own register.
   assign issue_entry = (action == mdcs_pkg::ACT_START) ? entry0_ff : nxt_entry;
   assign move_prod   = {16'b0, issue_entry.param_a} * {16'b0, steps_per_cm_ff};
   assign move_pos    = (move_prod > {13'b0, max_rail_position_ff}) ?
                        max_rail_position_ff : move_prod[18:0];

   assign move_sat = (move_elapsed_ff == '1) ? move_elapsed_ff : move_elapsed_ff + 32'd1;
   assign wait_sat = (wait_elapsed_ff == '1) ? wait_elapsed_ff : wait_elapsed_ff + 32'd1;

   assign add_ok = (op <= mdcs_pkg::OP_HOME)
                && !((op == mdcs_pkg::OP_DISPENSE) && (param_a >= 16'(UNIT_COUNT)))
                && (length_ff < LEN_WIDTH'(PROGRAM_DEPTH));
   assign wr_en  = accept && (action == mdcs_pkg::ACT_ADD) && add_ok;

   assign limit_fault = limit_hit && (last_target_ff > 20'sd0)
                     && (move_sat > {16'b0, settle_ticks_ff})
                     && (mode_ff != mdcs_pkg::MODE_FAULT);

   // A step at or past the end of the list counts as a finished no-op.
   assign cur_op = (step_ff < length_ff) ? cur_entry.op : mdcs_pkg::OP_NOP;
   assign cur_a  = (step_ff < length_ff) ? cur_entry.param_a : 16'b0;

   always_comb begin
      done  = 1'b0;
      fault = 1'b0;
      case (cur_op)
         mdcs_pkg::OP_MOVE: begin
            done  = at_target;
            fault = move_sat > max_move_ticks_ff;
         end
         mdcs_pkg::OP_DISPENSE: begin
            done = dispenser_idle;
         end
         mdcs_pkg::OP_WAIT: begin
            done = wait_sat >= {16'b0, cur_a};
         end
         mdcs_pkg::OP_HOME: begin
            done  = limit_hit;
            fault = !limit_hit && (at_target || (move_sat > max_move_ticks_ff));
         end
         default: begin
            done = 1'b1;
         end
      endcase
   end

   always_comb begin
      length_in       = length_ff;
      step_in         = step_ff;
      mode_in         = mode_ff;
      last_target_in  = last_target_ff;
      move_elapsed_in = move_elapsed_ff;
      wait_elapsed_in = wait_elapsed_ff;
      res             = '0;
      do_issue        = 1'b0;
      issue_valid     = 1'b0;

      if (accept) begin
         case (action)
            mdcs_pkg::ACT_ADD: begin
               if (add_ok) begin
                  length_in    = length_ff + LEN_WIDTH'(1);
                  res.accepted = 1'b1;
               end
            end
            mdcs_pkg::ACT_CLEAR: begin
               length_in = '0;
            end
            mdcs_pkg::ACT_START: begin
               if ((mode_ff == mdcs_pkg::MODE_IDLE) && (length_ff != '0)) begin
                  step_in      = '0;
                  do_issue     = 1'b1;
                  issue_valid  = 1'b1;
                  mode_in      = mdcs_pkg::MODE_RUN;
                  res.accepted = 1'b1;
               end
            end
            default: begin
               move_elapsed_in = move_sat;
               wait_elapsed_in = wait_sat;
               if (limit_fault) begin
                  mode_in      = mdcs_pkg::MODE_FAULT;
                  res.stop_all = 1'b1;
               end else if (mode_ff == mdcs_pkg::MODE_RUN) begin
                  res.home_found = (cur_op == mdcs_pkg::OP_HOME) && limit_hit;
                  // A fault on the tick of completion wins over advancing.
                  if (fault) begin
                     mode_in      = mdcs_pkg::MODE_FAULT;
                     res.stop_all = 1'b1;
                  end else if (done) begin
                     step_in     = step_ff + LEN_WIDTH'(1);
                     do_issue    = 1'b1;
                     issue_valid = (step_ff + LEN_WIDTH'(1)) < length_ff;
                     if (!issue_valid) begin
                        res.drive_off = 1'b1;
                        mode_in       = mdcs_pkg::MODE_IDLE;
                     end
                  end
               end
            end
         endcase

         if (do_issue && issue_valid) begin
            case (issue_entry.op)
               mdcs_pkg::OP_MOVE: begin
                  res.move_cmd    = 1'b1;
                  res.move_target = {1'b0, move_pos};
                  last_target_in  = {1'b0, move_pos};
                  move_elapsed_in = '0;
               end
               mdcs_pkg::OP_DISPENSE: begin
                  res.dispense_cmd    = 1'b1;
                  res.dispense_unit   = issue_entry.param_a[4:0];
                  res.dispense_amount = issue_entry.param_b;
               end
               mdcs_pkg::OP_WAIT: begin
                  wait_elapsed_in = '0;
               end
               mdcs_pkg::OP_HOME: begin
                  res.move_cmd     = 1'b1;
                  res.move_target  = mdcs_pkg::HOME_TARGET;
                  res.homing_speed = 1'b1;
                  last_target_in   = mdcs_pkg::HOME_TARGET;
                  move_elapsed_in  = '0;
               end
               default: begin
               end
            endcase
         end
      end

      res.run_state = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff       <= '0;
         step_ff         <= '0;
         mode_ff         <= mdcs_pkg::MODE_IDLE;
         last_target_ff  <= '0;
         move_elapsed_ff <= '0;
         wait_elapsed_ff <= '0;
      end else begin
         length_ff       <= length_in;
         step_ff         <= step_in;
         mode_ff         <= mode_in;
         last_target_ff  <= last_target_in;
         move_elapsed_ff <= move_elapsed_in;
         wait_elapsed_ff <= wait_elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (length_ff == '0)) begin
         entry0_ff <= new_entry;
      end
   end

   // ---------------------------------------------------------------- output buffer

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_pop) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (out_valid_ff && !rsp_pop) begin
            skid_ff       <= res;
            skid_valid_ff <= 1'b1;
         end else begin
            out_ff       <= res;
            out_valid_ff <= 1'b1;
         end
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{PAD_WIDTH{1'b0}}, out_ff};

`ifndef SYNTHESIS
   // The second buffer entry is only ever filled behind a waiting first entry.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid while output entry empty");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.stop_all) |-> (out_ff.run_state == mdcs_pkg::MODE_FAULT))
      else $error("stop_all reported without fault state");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.move_cmd && out_ff.dispense_cmd))
      else $error("move and dispense issued by one result");

   assert property (@(posedge clock) disable iff (reset)
      length_ff <= LEN_WIDTH'(PROGRAM_DEPTH))
      else $error("program length beyond store depth");

   // Only reset leaves the fault state.
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == mdcs_pkg::MODE_FAULT) |=> (mode_ff == mdcs_pkg::MODE_FAULT))
      else $error("fault state left without reset");
`endif

endmodule
